// ===== hdl/rtphp_pkg.sv =====
package rtphp_pkg;

  // Fixed RTP header size in bytes.
  localparam int HEADER_BYTES = 12;

  // Version value that marks a valid RTP or RTCP packet.
  localparam logic [1:0] RTP_VERSION = 2'd2;

  // Payload types from RTCP_PT_LO up to, not including, RTCP_PT_HI are RTCP.
  localparam logic [6:0] RTCP_PT_LO = 7'd64;
  localparam logic [6:0] RTCP_PT_HI = 7'd96;

  // Packet class codes.
  localparam logic [1:0] CLASS_NONE = 2'd0;
  localparam logic [1:0] CLASS_RTP  = 2'd1;
  localparam logic [1:0] CLASS_RTCP = 2'd2;

  // Widths of the offset arithmetic: header end and offset with extension.
  localparam int HDR_END_W = 7;
  localparam int EXT_OFF_W = 19;

endpackage

// ===== hdl/rtp_header_parser.sv =====
// RTP header parser. A packet enters on the slave stream one byte per word,
// with s_axis_tlast on its final byte. For each packet one result word leaves
// on the master stream: the captured fixed header fields, the payload offset
// and the payload size in m_axis_tdata, and the packet class in m_axis_tuser.
// Header bytes that never arrived read as zero; bytes beyond MAX_PACKET_BYTES
// are dropped except for their last flag.
// The snapshot register loads at the edge that accepts the last byte and the
// result register loads from the snapshot when the output stage can take it.
// Throughput: one byte per cycle while s_axis_tready is high, set by the byte
// counter and capture logic; a new packet may start in the cycle after the
// previous last byte when the snapshot can advance.
// Reset clears the byte counter, the captured header and both valid flags.
// When the receiver stalls, the result word holds, the snapshot stage fills,
// and s_axis_tready drops only while both stages are occupied; bytes already
// counted are kept and nothing is lost.
module rtp_header_parser #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte [7:0]
  input  logic         s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // version [1:0], padding_flag [2], extension_flag [3], csrc_total [7:4],
  // marker_flag [8], payload_kind [15:9], seq_number [31:16],
  // media_time [63:32], source_id [95:64], payload_start [107:96],
  // payload_length [119:108]
  output logic [119:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser    // packet_class [1:0]
);
  import rtphp_pkg::*;

  localparam int CW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int PW = (CW > 8) ? CW : 8;
  localparam int OW = ((CW > EXT_OFF_W) ? CW : EXT_OFF_W) + 1;

  // Packet assembly state.
  logic [CW-1:0] byte_count, byte_count_next, count_inc;
  logic [95:0]   hdr, hdr_next;
  logic [15:0]   ext_words, ext_words_next;

  // Snapshot of a finished packet.
  logic          snap_valid;
  logic [CW-1:0] snap_len;
  logic [95:0]   snap_hdr;
  logic [15:0]   snap_ext;

  logic in_fire, last_fire, out_load, snap_adv;
  logic room;
  logic [PW-1:0] pos_w, hdr_end_w;
  logic [HDR_END_W-1:0] hdr_end;

  // Handshake between the stages.
  assign out_load      = !m_axis_tvalid || m_axis_tready;
  assign snap_adv      = snap_valid && out_load;
  assign s_axis_tready = !snap_valid || snap_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign last_fire     = in_fire && s_axis_tlast;

  // Byte position and the end of the CSRC list.
  assign room      = byte_count < CW'(MAX_PACKET_BYTES);
  assign count_inc = room ? byte_count + CW'(1) : byte_count;
  assign hdr_end   = HDR_END_W'(HEADER_BYTES) + {1'b0, hdr[91:88], 2'b00};
  assign pos_w     = PW'(byte_count);
  assign hdr_end_w = PW'(hdr_end);

  // Capture of header bytes and the extension length word.
  always_comb begin
    hdr_next       = hdr;
    ext_words_next = ext_words;
    if (in_fire && room) begin
      for (int k = 0; k < HEADER_BYTES; k++) begin
        if (pos_w == PW'(k)) begin
          hdr_next[95 - 8*k -: 8] = s_axis_tdata;
        end
      end
      if (pos_w >= PW'(HEADER_BYTES)) begin
        if (pos_w == hdr_end_w + PW'(2)) begin
          ext_words_next[15:8] = s_axis_tdata;
        end else if (pos_w == hdr_end_w + PW'(3)) begin
          ext_words_next[7:0] = s_axis_tdata;
        end
      end
    end
  end

  always_comb begin
    byte_count_next = byte_count;
    if (last_fire) begin
      byte_count_next = '0;
    end else if (in_fire) begin
      byte_count_next = count_inc;
    end
  end

  // Assembly registers clear after each packet.
  always_ff @(posedge clk) begin
    if (rst || last_fire) begin
      byte_count <= '0;
      hdr        <= '0;
      ext_words  <= '0;
    end else begin
      byte_count <= byte_count_next;
      hdr        <= hdr_next;
      ext_words  <= ext_words_next;
    end
  end

  // Snapshot stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (last_fire) begin
      snap_valid <= 1'b1;
    end else if (snap_adv) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_fire) begin
      snap_len <= in_fire ? count_inc : byte_count;
      snap_hdr <= hdr_next;
      snap_ext <= ext_words_next;
    end
  end

  // Classification and payload offset from the snapshot.
  logic [7:0]           b0, b1;
  logic [6:0]           pt;
  logic [1:0]           cls;
  logic [OW-1:0]        len_w, base_off, ext_off, off_sel, offset, plen;

  assign b0 = snap_hdr[95:88];
  assign b1 = snap_hdr[87:80];
  assign pt = b1[6:0];

  always_comb begin
    priority if (snap_len < CW'(HEADER_BYTES) || b0[7:6] != RTP_VERSION) begin
      cls = CLASS_NONE;
    end else if (pt >= RTCP_PT_LO && pt < RTCP_PT_HI) begin
      cls = CLASS_RTCP;
    end else begin
      cls = CLASS_RTP;
    end
  end

  assign len_w    = OW'(snap_len);
  assign base_off = OW'(HEADER_BYTES) + OW'({b0[3:0], 2'b00});
  assign ext_off  = base_off + OW'(4) + OW'({snap_ext, 2'b00});
  assign off_sel  = (b0[4] && len_w > base_off + OW'(4)) ? ext_off : base_off;
  assign offset   = (off_sel > len_w) ? len_w : off_sel;
  assign plen     = len_w - offset;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_adv) begin
      m_axis_tuser <= cls;
      m_axis_tdata <= {plen[11:0], offset[11:0], snap_hdr[31:0], snap_hdr[63:32],
                       snap_hdr[79:64], pt, b1[7], b0[3:0], b0[4], b0[5], b0[7:6]};
    end
  end

  // The byte counter never passes the packet size limit.
  assert property (@(posedge clk) disable iff (rst)
    byte_count <= CW'(MAX_PACKET_BYTES))
    else $error("byte counter beyond limit");

  // A last byte leaves a cleared counter and a full snapshot stage.
  assert property (@(posedge clk) disable iff (rst)
    last_fire |=> byte_count == '0 && snap_valid && hdr == '0)
    else $error("packet close did not clear state");

  // A snapshot that cannot advance is kept.
  assert property (@(posedge clk) disable iff (rst)
    snap_valid && !snap_adv |=> snap_valid && $stable(snap_hdr))
    else $error("stalled snapshot lost");

  // RTP and RTCP results always carry version two.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != CLASS_NONE |-> m_axis_tdata[1:0] == RTP_VERSION)
    else $error("classified packet with wrong version");

endmodule
